FILE: rtl/ssp_pkg.sv
`default_nettype none

package ssp_pkg;

  // Screen geometry and projection scaling
  localparam int SCREEN_WIDTH   = 1024;
  localparam int SCREEN_HEIGHT  = 512;
  localparam int VERTICAL_SHIFT = 0;
  localparam int HEIGHT_DIVISOR = 1;
  localparam int WIDTH_DIVISOR  = 1;

  localparam int HALF_W = SCREEN_WIDTH / 2;
  localparam int HALF_H = SCREEN_HEIGHT / 2;
  localparam bit VS_NEG = (VERTICAL_SHIFT < 0);
  localparam int VS_MAG = (VERTICAL_SHIFT < 0) ? -VERTICAL_SHIFT : VERTICAL_SHIFT;
  localparam int I32_MAX = 32'h7fff_ffff;
  localparam int CAP_H = I32_MAX / HEIGHT_DIVISOR;
  localparam int CAP_W = I32_MAX / WIDTH_DIVISOR;

  // Q16.16 depth: numerator scaled by one
  localparam int ONE_SHIFT = 16;

  // Divider widths: numerator up to |ny| << 16, divisor up to |ny| * HEIGHT_DIVISOR or WIDTH_DIVISOR
  localparam int QUO_W = 32;
  localparam int NUM_W = 84;
  localparam int DEN_W = 72;
  localparam int DIV_LAT = QUO_W + 2;

  // Port widths
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 168;
  localparam int OUT_USER_W = 2;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Register map, word index
  localparam logic [2:0] REG_CAMERA_X     = 3'd0;
  localparam logic [2:0] REG_CAMERA_Y     = 3'd1;
  localparam logic [2:0] REG_VIEW_DIR_X   = 3'd2;
  localparam logic [2:0] REG_VIEW_DIR_Y   = 3'd3;
  localparam logic [2:0] REG_VIEW_PLANE_X = 3'd4;
  localparam logic [2:0] REG_VIEW_PLANE_Y = 3'd5;

  localparam logic signed [31:0] RST_CAMERA_X     = 32'sd0;
  localparam logic signed [31:0] RST_CAMERA_Y     = 32'sd0;
  localparam logic signed [31:0] RST_VIEW_DIR_X   = 32'sd65536;
  localparam logic signed [31:0] RST_VIEW_DIR_Y   = 32'sd0;
  localparam logic signed [31:0] RST_VIEW_PLANE_X = 32'sd0;
  localparam logic signed [31:0] RST_VIEW_PLANE_Y = 32'sd43254;

  // Result tdata, last field (depth) in the low bits
  typedef struct packed {
    logic [3:0]         pad;
    logic signed [16:0] last_row;
    logic [15:0]        first_row;
    logic signed [16:0] last_column;
    logic [15:0]        first_column;
    logic [15:0]        sprite_width;
    logic [15:0]        sprite_height;
    logic signed [16:0] vertical_offset;
    logic signed [16:0] screen_column;
    logic signed [31:0] depth;
  } result_t;

  // Flags that ride beside the divider pipelines
  typedef struct packed {
    logic bad;
    logic dsign;
    logic csign;
    logic vsign;
  } side_t;

  function automatic logic signed [31:0] sat_s32(input logic neg, input logic ovf,
                                                input logic [31:0] q);
    logic signed [31:0] r;
    if (!neg) begin
      r = (ovf || q[31]) ? 32'sh7fff_ffff : signed'(q);
    end else begin
      r = (ovf || (q[31] && (q[30:0] != '0))) ? 32'sh8000_0000 : signed'(-q);
    end
    return r;
  endfunction

  function automatic logic [30:0] cap_u31(input logic ovf, input logic [31:0] q,
                                          input logic [30:0] cap);
    return (ovf || (q > {1'b0, cap})) ? cap : q[30:0];
  endfunction

  function automatic logic signed [16:0] sat_s17(input logic signed [34:0] v);
    logic signed [16:0] r;
    if (v > 35'sd65535) begin
      r = 17'sh0ffff;
    end else if (v < -35'sd65536) begin
      r = 17'sh10000;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] sat_u16(input logic signed [34:0] v);
    logic [15:0] r;
    if (v < 35'sd0) begin
      r = '0;
    end else if (v > 35'sd65535) begin
      r = 16'hffff;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ssp_div.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// ovf flags a quotient that does not fit in QW bits.
module ssp_div #(
  parameter int NW = 84,
  parameter int DW = 72,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf
);

  localparam int WW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] num_in_r;
  logic [DW-1:0] den_in_r;
  logic [WW-1:0] rem_r [0:QW-1];
  logic [DW-1:0] den_r [0:QW-1];
  logic [QW-1:0] quo_r [1:QW];
  logic          ovf_r [0:QW];

  always_ff @(posedge clk) begin
    if (en) begin
      num_in_r <= num;
      den_in_r <= den;
      ovf_r[0] <= WW'(num_in_r) >= (WW'(den_in_r) << QW);
      rem_r[0] <= WW'(num_in_r);
      den_r[0] <= den_in_r;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [WW-1:0] dsh;
    logic          take;
    logic [QW-1:0] qprev;

    assign dsh  = WW'(den_r[k-1]) << (QW - k);
    assign take = rem_r[k-1] >= dsh;

    if (k == 1) begin : g_first
      assign qprev = '0;
    end else begin : g_next
      assign qprev = quo_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k] <= qprev | (QW'(take) << (QW - k));
        ovf_r[k] <= ovf_r[k-1];
      end
    end

    if (k < QW) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? (rem_r[k-1] - dsh) : rem_r[k-1];
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  assign quo = quo_r[QW];
  assign ovf = ovf_r[QW];

endmodule

`default_nettype wire

FILE: rtl/sprite_screen_projection_top.sv
// Sprite screen projection for a raycaster.
// in_* : one sprite world position per transaction, tdata = {sprite_y, sprite_x},
//        both Q16.16 signed. out_* : one result per sprite, fields in tdata,
//        flags in tuser (bit 0 behind_camera, bit 1 invalid).
// cfg_* : APB-style port holding camera position, direction and plane vectors,
//        one 32-bit register per word; write only while no sprite is in flight.
// From input transaction to out_tvalid the pipeline has four stages for offset,
// products, differences and magnitudes, 34 in the bit-serial-per-stage
// dividers (input register, range check, 32 quotient bits), and three for
// saturation, draw bounds and the output register. One sprite per cycle.
// The whole pipeline advances when the output register is empty or taken;
// while the receiver stalls a full output, in_tready drops and every stage
// holds its contents. Reset clears all valid bits and reloads the camera
// registers (direction 1.0, 0; plane 0, about 0.66).
`default_nettype none

module sprite_screen_projection_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ssp_pkg::IN_DATA_W-1:0]     in_tdata,   // sprite_x, sprite_y
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // depth, screen_column, vertical_offset, sprite_height, sprite_width,
  // first_column, last_column, first_row, last_row, zero pad
  output logic [ssp_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [ssp_pkg::OUT_USER_W-1:0]    out_tuser,  // behind_camera, invalid
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ssp_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [ssp_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [ssp_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  import ssp_pkg::*;

  // Configuration
  logic signed [31:0] cam_x_r, cam_y_r, dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r   <= RST_CAMERA_X;
      cam_y_r   <= RST_CAMERA_Y;
      dir_x_r   <= RST_VIEW_DIR_X;
      dir_y_r   <= RST_VIEW_DIR_Y;
      plane_x_r <= RST_VIEW_PLANE_X;
      plane_y_r <= RST_VIEW_PLANE_Y;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CAMERA_X:     cam_x_r   <= signed'(cfg_pwdata);
        REG_CAMERA_Y:     cam_y_r   <= signed'(cfg_pwdata);
        REG_VIEW_DIR_X:   dir_x_r   <= signed'(cfg_pwdata);
        REG_VIEW_DIR_Y:   dir_y_r   <= signed'(cfg_pwdata);
        REG_VIEW_PLANE_X: plane_x_r <= signed'(cfg_pwdata);
        REG_VIEW_PLANE_Y: plane_y_r <= signed'(cfg_pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CAMERA_X:     cfg_prdata = cam_x_r;
      REG_CAMERA_Y:     cfg_prdata = cam_y_r;
      REG_VIEW_DIR_X:   cfg_prdata = dir_x_r;
      REG_VIEW_DIR_Y:   cfg_prdata = dir_y_r;
      REG_VIEW_PLANE_X: cfg_prdata = plane_x_r;
      REG_VIEW_PLANE_Y: cfg_prdata = plane_y_r;
      default:          cfg_prdata = '0;
    endcase
  end

  // Pipeline control
  logic adv;
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, f1_vld_r, f2_vld_r, out_vld_r;
  logic dv_vld_r [0:DIV_LAT-1];

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      f1_vld_r  <= 1'b0;
      f2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) dv_vld_r[i] <= 1'b0;
    end else if (adv) begin
      s1_vld_r    <= in_tvalid;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      s4_vld_r    <= s3_vld_r;
      dv_vld_r[0] <= s4_vld_r;
      for (int i = 1; i < DIV_LAT; i++) dv_vld_r[i] <= dv_vld_r[i-1];
      f1_vld_r    <= dv_vld_r[DIV_LAT-1];
      f2_vld_r    <= f1_vld_r;
      out_vld_r   <= f2_vld_r;
    end
  end

  // Stage 1: offset from camera
  logic signed [31:0] sx, sy;
  logic signed [32:0] rx_r, ry_r;

  assign sx = signed'(in_tdata[31:0]);
  assign sy = signed'(in_tdata[63:32]);

  always_ff @(posedge clk) begin
    if (adv) begin
      rx_r <= 33'(sx) - 33'(cam_x_r);
      ry_r <= 33'(sy) - 33'(cam_y_r);
    end
  end

  // Stage 2: products of the inverse camera matrix
  logic signed [64:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [63:0] pe_r, pf_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r <= 65'(dir_y_r) * 65'(rx_r);
      pb_r <= 65'(dir_x_r) * 65'(ry_r);
      pc_r <= 65'(plane_x_r) * 65'(ry_r);
      pd_r <= 65'(plane_y_r) * 65'(rx_r);
      pe_r <= 64'(plane_x_r) * 64'(dir_y_r);
      pf_r <= 64'(dir_x_r) * 64'(plane_y_r);
    end
  end

  // Stage 3: lateral offset, depth numerator, determinant
  logic signed [65:0] nx_r, ny_r;
  logic signed [64:0] det_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      nx_r  <= 66'(pa_r) - 66'(pb_r);
      ny_r  <= 66'(pc_r) - 66'(pd_r);
      det_r <= 65'(pe_r) - 65'(pf_r);
    end
  end

  // Stage 4: magnitudes and signs
  logic signed [66:0] nsum;
  logic [65:0]        ny_mag_r;
  logic [64:0]        det_mag_r;
  logic [66:0]        nsum_mag_r;
  logic               ny_neg_r, det_neg_r, nsum_neg_r, bad_r;

  assign nsum = 67'(ny_r) + 67'(nx_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      ny_mag_r   <= ny_r[65] ? unsigned'(-ny_r) : unsigned'(ny_r);
      det_mag_r  <= det_r[64] ? unsigned'(-det_r) : unsigned'(det_r);
      nsum_mag_r <= nsum[66] ? unsigned'(-nsum) : unsigned'(nsum);
      ny_neg_r   <= ny_r[65];
      det_neg_r  <= det_r[64];
      nsum_neg_r <= nsum[66];
      bad_r      <= (det_r == '0) || (ny_r == '0);
    end
  end

  // Dividers
  logic [NUM_W-1:0] num_dep, num_col, num_vm, num_ht;
  logic [DEN_W-1:0] den_dep, den_ny, den_h, den_w;
  logic [QUO_W-1:0] q_dep, q_col, q_vm, q_h, q_w;
  logic             o_dep, o_col, o_vm, o_h, o_w;
  side_t            side_in;
  side_t            side_r [0:DIV_LAT-1];

  assign num_dep = NUM_W'(ny_mag_r) << ONE_SHIFT;
  assign num_col = NUM_W'(nsum_mag_r) * NUM_W'(HALF_W);
  assign num_vm  = NUM_W'(det_mag_r) * NUM_W'(VS_MAG);
  assign num_ht  = NUM_W'(det_mag_r) * NUM_W'(SCREEN_HEIGHT);
  assign den_dep = DEN_W'(det_mag_r);
  assign den_ny  = DEN_W'(ny_mag_r);
  assign den_h   = DEN_W'(ny_mag_r) * DEN_W'(HEIGHT_DIVISOR);
  assign den_w   = DEN_W'(ny_mag_r) * DEN_W'(WIDTH_DIVISOR);

  assign side_in.bad   = bad_r;
  assign side_in.dsign = ny_neg_r ^ det_neg_r;
  assign side_in.csign = nsum_neg_r ^ ny_neg_r;
  assign side_in.vsign = det_neg_r ^ ny_neg_r ^ VS_NEG;

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_in;
      for (int i = 1; i < DIV_LAT; i++) side_r[i] <= side_r[i-1];
    end
  end

  ssp_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W)) u_div_depth (
    .clk(clk), .en(adv), .num(num_dep), .den(den_dep), .quo(q_dep), .ovf(o_dep)
  );
  ssp_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W)) u_div_col (
    .clk(clk), .en(adv), .num(num_col), .den(den_ny), .quo(q_col), .ovf(o_col)
  );
  ssp_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W)) u_div_vshift (
    .clk(clk), .en(adv), .num(num_vm), .den(den_ny), .quo(q_vm), .ovf(o_vm)
  );
  ssp_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W)) u_div_height (
    .clk(clk), .en(adv), .num(num_ht), .den(den_h), .quo(q_h), .ovf(o_h)
  );
  ssp_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W)) u_div_width (
    .clk(clk), .en(adv), .num(num_ht), .den(den_w), .quo(q_w), .ovf(o_w)
  );

  // F1: saturate depth, column and offset to 32-bit signed, cap sizes; sizes pre-divided in the divisor
  side_t              side_out;
  logic signed [31:0] dep_f1_r, col_f1_r, vm_f1_r;
  logic [30:0]        sh_f1_r, sw_f1_r;
  logic               bad_f1_r, dsign_f1_r;

  assign side_out = side_r[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      dep_f1_r   <= sat_s32(side_out.dsign, o_dep, q_dep);
      col_f1_r   <= sat_s32(side_out.csign, o_col, q_col);
      vm_f1_r    <= sat_s32(side_out.vsign, o_vm, q_vm);
      sh_f1_r    <= cap_u31(o_h, q_h, 31'(CAP_H));
      sw_f1_r    <= cap_u31(o_w, q_w, 31'(CAP_W));
      bad_f1_r   <= side_out.bad;
      dsign_f1_r <= side_out.dsign;
    end
  end

  // F2: draw bounds before clipping
  logic signed [34:0] ys_r, ye_r, xs_r, xe_r;
  logic signed [34:0] half_sh, half_sw, mid_row;
  logic signed [31:0] dep_f2_r, col_f2_r, vm_f2_r;
  logic [30:0]        sh_f2_r, sw_f2_r;
  logic               bad_f2_r, dsign_f2_r;

  assign half_sh = signed'(35'(sh_f1_r >> 1));
  assign half_sw = signed'(35'(sw_f1_r >> 1));
  assign mid_row = 35'(HALF_H) + 35'(vm_f1_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      ys_r       <= mid_row - half_sh;
      ye_r       <= mid_row + half_sh;
      xs_r       <= 35'(col_f1_r) - half_sw;
      xe_r       <= 35'(col_f1_r) + half_sw;
      dep_f2_r   <= dep_f1_r;
      col_f2_r   <= col_f1_r;
      vm_f2_r    <= vm_f1_r;
      sh_f2_r    <= sh_f1_r;
      sw_f2_r    <= sw_f1_r;
      bad_f2_r   <= bad_f1_r;
      dsign_f2_r <= dsign_f1_r;
    end
  end

  // Output register: clip to screen and saturate to field ranges; invalid sprites give all-zero fields
  result_t            res_nxt, res_r;
  logic [1:0]         user_nxt, user_r;
  logic signed [34:0] ye_clip, xe_clip;

  assign ye_clip = (ye_r >= 35'(SCREEN_HEIGHT)) ? 35'(SCREEN_HEIGHT - 1) : ye_r;
  assign xe_clip = (xe_r >= 35'(SCREEN_WIDTH)) ? 35'(SCREEN_WIDTH - 1) : xe_r;

  always_comb begin
    res_nxt                 = '0;
    user_nxt                = 2'b11;
    if (!bad_f2_r) begin
      res_nxt.depth           = dep_f2_r;
      res_nxt.screen_column   = sat_s17(35'(col_f2_r));
      res_nxt.vertical_offset = sat_s17(35'(vm_f2_r));
      res_nxt.sprite_height   = sat_u16(signed'(35'(sh_f2_r)));
      res_nxt.sprite_width    = sat_u16(signed'(35'(sw_f2_r)));
      res_nxt.first_column    = sat_u16(xs_r);
      res_nxt.last_column     = sat_s17(xe_clip);
      res_nxt.first_row       = sat_u16(ys_r);
      res_nxt.last_row        = sat_s17(ye_clip);
      user_nxt                = {1'b0, dsign_f2_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r  <= res_nxt;
      user_r <= user_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = res_r;
  assign out_tuser  = user_r;

endmodule

`default_nettype wire

FILE: rtl/ssp_chk.sv
`default_nettype none

module ssp_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [ssp_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [ssp_pkg::OUT_USER_W-1:0] out_tuser
);

  import ssp_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Input backpressure only comes from a stalled result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("in_tready low without output stall");

  // Invalid sprites carry behind set and all-zero fields
  a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0] && (out_tdata == '0))
    else $error("invalid result not cleared");

  // Last row and last column never pass the bottom or right screen edge
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[163:147]) <= SCREEN_HEIGHT - 1) &&
                   ($signed(out_tdata[130:114]) <= SCREEN_WIDTH - 1))
    else $error("last row or column off screen");

  // Reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind sprite_screen_projection_top ssp_chk u_ssp_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);

`default_nettype wire
